// ----- sv/cobs_crc_frame_decoder_top_macros.svh -----
// Assertion macros shared by the COBS/CRC frame decoder modules.
// Takes no other file; a module pulls it in with an include.
`ifndef COBS_CRC_FRAME_DECODER_TOP_MACROS_SVH
`define COBS_CRC_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CCFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define CCFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ccfd_pkg.sv -----
// Package for the COBS/CRC frame decoder: status codes, register indexes,
// frame limits, the result record and the byte-wide CRC-16 fold.
// Depends on nothing.
`timescale 1ns / 1ps

package ccfd_pkg;

  localparam int MAX_FRAME = 256;
  localparam int LEN_W = $clog2(MAX_FRAME + 1);

  localparam logic [7:0] KEY_BYTE = 8'h0A;
  localparam logic [7:0] NO_ZERO_CODE = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP = 16'h8000;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd254;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_CODE = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TOO_SHORT = 3'd4,
    ST_CRC_BAD   = 3'd5
  } status_t;

  // Results caused by one accepted word: at most one payload byte, then
  // at most one end-of-frame status.
  typedef struct packed {
    logic       pay_v;
    logic [7:0] pay_byte;
    logic       st_v;
    status_t    st_code;
  } result_t;

  // CRC-16/CCITT-FALSE over one byte, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/cobs_crc_frame_decoder_top.sv -----
// Top level of the COBS frame decoder with CRC-16/CCITT-FALSE check.
// Depends on ccfd_pkg, ccfd_core and ccfd_out.
//
//   channel   direction  word contents
//   --------  ---------  -------------------------------------------------
//   s_*       in         tdata = encoded byte, tlast = last byte of frame
//   m_*       out        tdata = payload byte, tlast = status word,
//                        tuser = status code
//   cfg_*     in         write of crc_seed (index 0) or max_payload (1)
//
// Each accepted word is decoded in the cycle it is taken and its results
// land in a two-entry result register, so a word is accepted every cycle
// as long as the consumer keeps up. A final word that also releases a
// payload byte yields two output words and stalls the input while both are
// held; that two-entry register sets the peak rate. Reset is synchronous
// and returns the frame state and both registers to their reset values. The
// input stalls only while the result register cannot empty in that cycle.
`timescale 1ns / 1ps

module cobs_crc_frame_decoder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] in_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [7:0] out_byte
  output logic                             m_tlast,
  output logic [2:0]                       m_tuser,   // [2:0] status
  input  logic                             cfg_we,
  input  logic [ccfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccfd_pkg::*;

  result_t res;
  logic    accept;

  // A word is taken when the result register can hold what it produces.
  assign accept = s_tvalid & s_tready;

  ccfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (s_tdata),
    .frame_end (s_tlast),
    .res       (res)
  );

  ccfd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .load_ok  (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- sv/ccfd_core.sv -----
// Frame state, configuration registers and the one-word decode step:
// de-keying, COBS group tracking, two-byte hold, CRC and status.
// Depends on ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ccfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic [7:0]                       in_byte,
  input  logic                             frame_end,
  output ccfd_pkg::result_t                res
);
  import ccfd_pkg::*;

  logic [15:0]      crc_seed;
  logic [7:0]       max_payload;

  logic [7:0]       group_left, group_left_next;
  logic [7:0]       group_code, group_code_next;
  logic             at_frame_start, at_frame_start_next;
  logic [7:0]       hold0, hold0_next;
  logic [7:0]       hold1, hold1_next;
  logic [1:0]       hold_count, hold_count_next;
  logic [LEN_W-1:0] decoded_length, decoded_length_next;
  logic [15:0]      running_crc, running_crc_next;
  status_t          error_code, error_code_next;

  logic [7:0]       b;
  logic             push_req;
  logic [7:0]       push_val;
  logic [LEN_W-1:0] payload_len;
  status_t          st;

  always_comb begin
    b = in_byte ^ KEY_BYTE;
    group_left_next = group_left;
    group_code_next = group_code;
    at_frame_start_next = 1'b0;
    hold0_next = hold0;
    hold1_next = hold1;
    hold_count_next = hold_count;
    decoded_length_next = decoded_length;
    running_crc_next = at_frame_start ? crc_seed : running_crc;
    error_code_next = error_code;
    push_req = 1'b0;
    push_val = 8'h00;
    payload_len = '0;
    st = ST_OK;
    res = '0;

    if (error_code == ST_OK) begin
      if (group_left == 8'h00) begin
        // A group just ended: put back the zero it stood for.
        push_req = (group_code != NO_ZERO_CODE);
      end else begin
        group_left_next = group_left - 8'd1;
        push_req = 1'b1;
        push_val = b;
      end
    end

    if (push_req) begin
      if (decoded_length >= LEN_W'(MAX_FRAME)) begin
        error_code_next = ST_TOO_LONG;
      end else begin
        decoded_length_next = decoded_length + LEN_W'(1);
        if (hold_count >= 2'd2) begin
          res.pay_v = 1'b1;
          res.pay_byte = hold0;
          running_crc_next = crc_fold(running_crc_next, hold0);
          hold0_next = hold1;
          hold1_next = push_val;
        end else begin
          if (hold_count[0]) begin
            hold1_next = push_val;
          end else begin
            hold0_next = push_val;
          end
          hold_count_next = hold_count + 2'd1;
        end
      end
    end

    // The word opens a new group unless the frame is in error, already or by this word.
    if (error_code == ST_OK && group_left == 8'h00 && error_code_next == ST_OK) begin
      if (b == 8'h00) begin
        error_code_next = ST_ZERO_CODE;
      end else begin
        group_code_next = b;
        group_left_next = b - 8'd1;
      end
    end

    if (frame_end) begin
      payload_len = decoded_length_next - LEN_W'(2);
      st = error_code_next;
      if (st == ST_OK) begin
        if (group_left_next != 8'h00) begin
          st = ST_TRUNCATED;
        end else if (decoded_length_next < LEN_W'(2)) begin
          st = ST_TOO_SHORT;
        end else if (payload_len > LEN_W'(max_payload)) begin
          st = ST_TOO_LONG;
        end else if ({hold1_next, hold0_next} != running_crc_next) begin
          st = ST_CRC_BAD;
        end
      end
      res.st_v = 1'b1;
      res.st_code = st;
      group_left_next = 8'h00;
      group_code_next = NO_ZERO_CODE;
      at_frame_start_next = 1'b1;
      hold0_next = 8'h00;
      hold1_next = 8'h00;
      hold_count_next = 2'd0;
      decoded_length_next = '0;
      running_crc_next = crc_seed;
      error_code_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= CRC_SEED_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_SEED: crc_seed <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_left <= 8'h00;
      group_code <= NO_ZERO_CODE;
      at_frame_start <= 1'b1;
      hold0 <= 8'h00;
      hold1 <= 8'h00;
      hold_count <= 2'd0;
      decoded_length <= '0;
      running_crc <= CRC_SEED_RESET;
      error_code <= ST_OK;
    end else if (accept) begin
      group_left <= group_left_next;
      group_code <= group_code_next;
      at_frame_start <= at_frame_start_next;
      hold0 <= hold0_next;
      hold1 <= hold1_next;
      hold_count <= hold_count_next;
      decoded_length <= decoded_length_next;
      running_crc <= running_crc_next;
      error_code <= error_code_next;
    end
  end

endmodule

// ----- sv/ccfd_out.sv -----
// Two-entry result register that serializes the payload byte and the
// status of one word onto the output stream. Depends on ccfd_pkg and
// the assertion macro header.
`timescale 1ns / 1ps
`include "cobs_crc_frame_decoder_top_macros.svh"

module ccfd_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ccfd_pkg::result_t res,
  output logic              load_ok,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [2:0]        m_tuser
);
  import ccfd_pkg::*;

  logic       pay_v;
  logic [7:0] pay_byte;
  logic       st_v;
  status_t    st_code;
  logic       pop;

  assign m_tvalid = pay_v | st_v;
  assign pop = m_tvalid & m_tready;
  // Room for a new word once whatever is held leaves with this handshake.
  assign load_ok = !m_tvalid || (m_tready && (pay_v ^ st_v));

  always_comb begin
    if (pay_v) begin
      m_tdata = pay_byte;
      m_tlast = 1'b0;
      m_tuser = 3'd0;
    end else begin
      m_tdata = 8'h00;
      m_tlast = st_v;
      m_tuser = st_v ? st_code : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pay_v <= 1'b0;
      st_v <= 1'b0;
    end else if (accept) begin
      pay_v <= res.pay_v;
      st_v <= res.st_v;
    end else if (pop) begin
      if (pay_v) begin
        pay_v <= 1'b0;
      end else begin
        st_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pay_byte <= res.pay_byte;
      st_code <= res.st_code;
    end
  end

  `CCFD_ASSERT_IMP(a_full_blocks_input, clk, rst, pay_v && st_v, !load_ok,
                   "input taken while two results are still held")
  `CCFD_ASSERT_NXT(a_status_follows_payload, clk, rst,
                   pop && pay_v && st_v && !accept, m_tvalid && m_tlast,
                   "status lost after its payload byte left")
  `CCFD_ASSERT_IMP(a_status_code_range, clk, rst, m_tvalid && m_tlast,
                   m_tuser <= 3'd5, "status code out of range")
  `CCFD_ASSERT_NXT(a_no_overwrite, clk, rst, m_tvalid && !m_tready,
                   m_tvalid, "held result dropped without a handshake")

endmodule

// ----- tb/sv/tb_cobs_crc_frame_decoder_top.sv -----
// Self-checking testbench for cobs_crc_frame_decoder_top: encoded frames in,
// payload and status words out, compared against a built-in decoder model.
// Depends on ccfd_pkg and the cobs_crc_frame_decoder_top RTL.
`timescale 1ns / 1ps

module tb_cobs_crc_frame_decoder_top;
  import ccfd_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 300000;

  // One output word as the decoder should produce it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    status_t    code;
  } out_word_t;

  // Ways in which a generated frame is damaged before it is sent.
  typedef enum {
    FL_NONE,
    FL_BAD_CRC,
    FL_CUT,
    FL_ZERO_CODE,
    FL_NOISE
  } flaw_t;

  // Scoreboard: a bit-exact model of the decoder plus the queue of output
  // words that it predicts, checked in order as the DUT emits them.
  class frame_scoreboard;
    logic [15:0] seed_reg;
    logic [7:0]  limit_reg;
    logic [7:0]  grp_left;
    logic [7:0]  grp_code;
    bit          fresh;
    logic [7:0]  held [2];
    int          held_n;
    int          dec_len;
    logic [15:0] crc;
    status_t     err;
    out_word_t   expected_words [$];
    int          errors;

    function new();
      seed_reg  = CRC_SEED_RESET;
      limit_reg = MAX_PAYLOAD_RESET;
      errors    = 0;
      clear_frame();
    endfunction

    // CRC-16/CCITT-FALSE, one byte, processed bit by bit from the MSB.
    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ d[i];
        r  = {r[14:0], 1'b0};
        if (fb) r = r ^ 16'h1021;
      end
      return r;
    endfunction

    function void clear_frame();
      grp_left = 8'h00;
      grp_code = NO_ZERO_CODE;
      fresh    = 1'b1;
      held[0]  = 8'h00;
      held[1]  = 8'h00;
      held_n   = 0;
      dec_len  = 0;
      crc      = seed_reg;
      err      = ST_OK;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_CRC_SEED) seed_reg = value;
      else if (idx == CFG_MAX_PAYLOAD) limit_reg = value[7:0];
    endfunction

    function void expect_word(logic [7:0] data, logic last, status_t code);
      out_word_t w;
      w.data = data;
      w.last = last;
      w.code = code;
      expected_words.push_back(w);
    endfunction

    // A decoded byte enters the two-byte hold; the byte it displaces becomes
    // payload and is folded into the running CRC.
    function void push_decoded(logic [7:0] b);
      if (dec_len >= MAX_FRAME) begin
        err = ST_TOO_LONG;
        return;
      end
      dec_len++;
      if (held_n >= 2) begin
        expect_word(held[0], 1'b0, ST_OK);
        crc     = crc_byte(crc, held[0]);
        held[0] = held[1];
        held[1] = b;
      end else begin
        held[held_n] = b;
        held_n++;
      end
    endfunction

    // Called for every word the DUT accepts on its input.
    function void note_word(logic [7:0] raw, logic last);
      logic [7:0] b;
      status_t    st;
      b = raw ^ KEY_BYTE;
      if (fresh) begin
        crc   = seed_reg;
        fresh = 1'b0;
      end
      if (err == ST_OK) begin
        if (grp_left == 8'h00) begin
          if (grp_code != NO_ZERO_CODE) push_decoded(8'h00);
          if (err == ST_OK) begin
            if (b == 8'h00) begin
              err = ST_ZERO_CODE;
            end else begin
              grp_code = b;
              grp_left = b - 8'd1;
            end
          end
        end else begin
          grp_left--;
          push_decoded(b);
        end
      end
      if (last) begin
        st = err;
        if (st == ST_OK) begin
          if (grp_left != 8'h00) st = ST_TRUNCATED;
          else if (dec_len < 2) st = ST_TOO_SHORT;
          else if (dec_len - 2 > int'(limit_reg)) st = ST_TOO_LONG;
          else if ({held[1], held[0]} != crc) st = ST_CRC_BAD;
        end
        expect_word(8'h00, 1'b1, st);
        clear_frame();
      end
    endfunction

    // Called for every word the DUT hands over on its output.
    function void check_word(logic [7:0] data, logic last, logic [2:0] code);
      out_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: out_byte %02h is_status %0b status %0d",
               data, last, code);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (data !== w.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("is_status mismatch: expected %0b, actual %0b", w.last, last);
        errors++;
      end
      if (code !== 3'(w.code)) begin
        $error("status mismatch: expected %0d, actual %0d", w.code, code);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_byte
  logic       s_tlast;   // frame_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic       m_tlast;   // is_status
  logic [2:0] m_tuser;   // [2:0] status
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frame_scoreboard sb;
  bit          quiet = 1'b0;     // no idling on either side when set
  int          stall_left = 0;
  int          cycles = 0;
  int          words_sent = 0;
  logic [15:0] frame_seed;       // seed the generator uses for frame CRCs

  cobs_crc_frame_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side. A word is taken at an edge where tvalid and tready were
  // both high before the edge; tready then goes low in random bursts,
  // except in the quiet tail of the run.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 16);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one input word and returns right after the edge that takes it.
  // Now and then the input goes idle first for a random burst of cycles.
  task automatic send_word(input logic [7:0] raw, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(raw, last);
    words_sent++;
  endtask

  // Builds one frame: payload, CRC trailer (low byte first), COBS groups and
  // the line key, then damages it as asked and sends it word by word.
  task automatic send_frame(input int pay_len, input flaw_t flaw);
    logic [7:0]  dec [$];
    logic [7:0]  enc [$];
    logic [15:0] c;
    logic [7:0]  b;
    logic [7:0]  code;
    int          code_at;
    int          n;
    c = frame_seed;
    for (int i = 0; i < pay_len; i++) begin
      case ($urandom_range(0, 7))
        0, 1: b = 8'h00;
        2: b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      dec.push_back(b);
      c = frame_scoreboard::crc_byte(c, b);
    end
    if (flaw == FL_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    dec.push_back(c[7:0]);
    dec.push_back(c[15:8]);

    // Standard COBS: each group starts with its length code; a full group of
    // 254 data bytes gets code 0xFF and implies no zero after it.
    enc.push_back(8'h00);
    code_at = 0;
    code    = 8'h01;
    foreach (dec[i]) begin
      if (dec[i] == 8'h00) begin
        enc[code_at] = code;
        code_at      = enc.size();
        enc.push_back(8'h00);
        code = 8'h01;
      end else begin
        enc.push_back(dec[i]);
        code++;
        if (code == NO_ZERO_CODE) begin
          enc[code_at] = code;
          code_at      = enc.size();
          enc.push_back(8'h00);
          code = 8'h01;
        end
      end
    end
    enc[code_at] = code;

    case (flaw)
      FL_CUT: begin
        n = $urandom_range(1, (enc.size() > 4) ? 3 : enc.size() - 1);
        repeat (n) void'(enc.pop_back());
      end
      FL_ZERO_CODE: enc[$urandom_range(0, enc.size() - 1)] = 8'h00;
      FL_NOISE: begin
        enc.delete();
        repeat ($urandom_range(1, 12)) enc.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase

    // Noise is already raw line data; everything else gets the line key.
    foreach (enc[i]) begin
      b = (flaw == FL_NOISE) ? enc[i] : enc[i] ^ KEY_BYTE;
      send_word(b, i == enc.size() - 1);
    end
  endtask

  // Lets every predicted word come out, then waits on until a word that
  // caused no output has surely left the pipeline as well.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, one per cycle, while the decoder is idle.
  task automatic program_regs(input logic [15:0] seed, input logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CRC_SEED;
    cfg_data  <= seed;
    @(posedge clk);
    sb.set_reg(CFG_CRC_SEED, seed);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= {8'h00, limit};
    @(posedge clk);
    sb.set_reg(CFG_MAX_PAYLOAD, {8'h00, limit});
    cfg_we     <= 1'b0;
    frame_seed  = seed;
  endtask

  // One register setting, then random frames until the word budget is used.
  // Most frames are well formed so that payload and CRC paths are exercised;
  // the rest carry a bad CRC, a cut tail, a zero code or plain noise. With a
  // small payload limit, some lengths sit right at and just above it.
  task automatic run_phase(input logic [15:0] seed, input logic [7:0] limit,
                           input int budget);
    int    start;
    int    len;
    int    pick;
    flaw_t flaw;
    drain();
    program_regs(seed, limit);
    start = words_sent;
    while (words_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) flaw = FL_NONE;
      else if (pick < 75) flaw = FL_BAD_CRC;
      else if (pick < 85) flaw = FL_CUT;
      else if (pick < 93) flaw = FL_ZERO_CODE;
      else flaw = FL_NOISE;
      len = $urandom_range(0, 12);
      if (limit <= 12 && $urandom_range(0, 3) == 0) len = limit + $urandom_range(0, 1);
      send_frame(len, flaw);
    end
  endtask

  initial begin
    sb = new();
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_CRC_SEED;
    cfg_data  <= '0;
    frame_seed = CRC_SEED_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    program_regs(CRC_SEED_RESET, MAX_PAYLOAD_RESET);

    // Directed frames.
    // The shortest good frame: nothing but the CRC trailer.
    send_frame(0, FL_NONE);
    // A zero code opens the frame; the raw 0x00 after it must be ignored.
    send_word(KEY_BYTE, 1'b0);
    send_word(8'h00, 1'b1);
    // A lone raw 0xFF opens a long group that never closes: truncated.
    send_word(8'hFF, 1'b1);
    // An empty group only: nothing decoded, so the frame is too short.
    send_word(8'h01 ^ KEY_BYTE, 1'b1);
    // One decoded byte is still too short.
    send_word(8'h02 ^ KEY_BYTE, 1'b0);
    send_word(8'hFF, 1'b1);
    // Wrong trailer, then a good frame with payload through the hold.
    send_frame(3, FL_BAD_CRC);
    send_frame(2, FL_NONE);

    // Random phases across several register settings, extremes included.
    run_phase(16'($urandom_range(1, 16'hFFFE)), 8'd254, 30);
    // The frame overflows the decoded-length limit while its groups are open.
    send_frame(255, FL_NONE);
    run_phase(16'h0000, 8'd0, 20);
    run_phase(16'hFFFF, 8'd1, 20);
    run_phase(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 254)), 20);
    quiet = 1'b1;
    run_phase(16'hFFFF, 8'd254, 20);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
